>>> src/tsoc_pkg.sv
// Shared types and constants for the transpose self-organizing key store.
// Holds the transfer structs, controller state and command types.
// Depends on nothing.
`default_nettype none

package tsoc_pkg;

  localparam int unsigned CapacityDef = 8;
  localparam int unsigned KeyBitsDef  = 32;

  localparam logic OpLookup = 1'b0;
  localparam logic OpFlush  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] lookup_key;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  final_position;
    logic        evicted;
    logic [31:0] evicted_key;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StUpd
  } state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic commit;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> src/tsoc_ctrl.sv
// Controller for the key store: sequences accept, compare and write-back,
// and owns the output valid flag. Depends on tsoc_pkg.
`default_nettype none

module tsoc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tsoc_pkg::ctrl_cmd_t     cmd_o
);

  tsoc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsoc_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    in_stall_o  = 1'b1;
    state_d     = state_q;
    cmd_o       = '0;
    case (state_q)
      tsoc_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = tsoc_pkg::StEval;
        end
      end
      tsoc_pkg::StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = tsoc_pkg::StUpd;
      end
      tsoc_pkg::StUpd: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          in_stall_o   = 1'b0;
          state_d      = in_valid_i ? tsoc_pkg::StEval : tsoc_pkg::StIdle;
        end
      end
      default: begin
        state_d = tsoc_pkg::StIdle;
      end
    endcase
    accept      = in_valid_i && !in_stall_o;
    cmd_o.load  = accept;
    out_valid_d = cmd_o.commit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> src/tsoc_dp.sv
// Datapath for the key store: slot registers, parallel compare, transpose swap,
// insert, eviction, flush and the result register. Depends on tsoc_pkg.
`default_nettype none

module tsoc_dp #(
  parameter int unsigned CAPACITY = tsoc_pkg::CapacityDef,
  parameter int unsigned KEY_BITS = tsoc_pkg::KeyBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tsoc_pkg::ctrl_cmd_t cmd_i,
  input  wire tsoc_pkg::in_item_t  in_data_i,
  output tsoc_pkg::out_item_t      out_data_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned InExtW = 32 + KEY_BITS;

  logic                    op_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [InExtW-1:0]       key_in_ext;
  logic [KEY_BITS-1:0]     slot_q [CAPACITY];
  logic [KEY_BITS-1:0]     slot_d [CAPACITY];
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CAPACITY-1:0]     match_q, match_d;
  logic [CAPACITY-1:0]     first;
  logic [IdxW-1:0]         hit_idx;
  logic [IdxW-1:0]         pos_idx;
  logic [IdxW+2:0]         pos_ext;
  logic [InExtW-1:0]       ev_ext;
  logic                    hit;
  logic                    full;
  logic                    flush;
  tsoc_pkg::out_item_t     res_q, res_d;

  assign key_in_ext = InExtW'(in_data_i.lookup_key);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.opcode;
      key_q <= key_in_ext[KEY_BITS-1:0];
    end
    if (cmd_i.eval) begin
      match_q <= match_d;
    end
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (slot_q[i] == key_q) && (CntW'(i) < cnt_q);
    end
  end

  always_comb begin
    flush   = (op_q == tsoc_pkg::OpFlush);
    first   = match_q & ((~match_q) + CAPACITY'(1));
    hit     = |match_q;
    full    = (cnt_q == CntW'(CAPACITY));
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end

    if (hit) begin
      pos_idx = (hit_idx == '0) ? '0 : hit_idx - IdxW'(1);
    end else if (!full) begin
      pos_idx = IdxW'(cnt_q);
    end else begin
      pos_idx = IdxW'(CAPACITY - 1);
    end
    pos_ext = (IdxW + 3)'(pos_idx);
    ev_ext  = InExtW'(slot_q[CAPACITY-1]);

    slot_d = slot_q;
    cnt_d  = cnt_q;
    res_d  = '0;
    if (cmd_i.commit) begin
      if (flush) begin
        cnt_d = '0;
      end else begin
        res_d.hit            = hit;
        res_d.final_position = pos_ext[2:0];
        res_d.evicted        = !hit && full;
        res_d.evicted_key    = (!hit && full) ? ev_ext[31:0] : '0;
        for (int i = 0; i < CAPACITY; i++) begin
          if (hit) begin
            if (i < CAPACITY - 1) begin
              if (first[(i + 1) % CAPACITY]) begin
                slot_d[i] = slot_q[(i + 1) % CAPACITY];
              end
            end
            if (i > 0) begin
              if (first[i]) begin
                slot_d[i] = slot_q[(i + CAPACITY - 1) % CAPACITY];
              end
            end
          end else if (!full) begin
            if (cnt_q == CntW'(i)) begin
              slot_d[i] = key_q;
            end
          end else if (i == CAPACITY - 1) begin
            slot_d[i] = key_q;
          end
        end
        if (!hit && !full) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
    end
  end

  assign out_data_o = res_q;

endmodule

`default_nettype wire

>>> src/transpose_self_organizing_cache_core.sv
// Transpose self-organizing key store, top level. Each item taken goes
// through the registered parallel compare, then the write-back, which registers
// its result and waits while the output stalls; no new item is taken before it.
// Reset clears the controller, the output valid flag and the fill count;
// key slots are not cleared and hold their contents until written.
// Depends on tsoc_pkg, tsoc_ctrl and tsoc_dp.
`default_nettype none

module transpose_self_organizing_cache_core #(
  parameter int unsigned CAPACITY = tsoc_pkg::CapacityDef,
  parameter int unsigned KEY_BITS = tsoc_pkg::KeyBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tsoc_pkg::in_item_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tsoc_pkg::out_item_t     out_data_o
);

  tsoc_pkg::ctrl_cmd_t cmd;

  tsoc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tsoc_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
